// ===== src/mtep_pkg.sv =====
// Shared types, constants and helper functions of the MIDI track event parser.
// Used by mtep_parse, mtep_outq and midi_track_event_parser_unit; depends on nothing.

package mtep_pkg;

    localparam int DEFAULT_TIME_WIDTH = 32;

    // Result kinds.
    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;

    // Byte values with a fixed meaning in a track.
    localparam logic [7:0] VLV_MASK      = 8'h7F;
    localparam logic [7:0] STATUS_BIT    = 8'h80;
    localparam logic [7:0] SYSTEM_BASE   = 8'hF0;
    localparam logic [7:0] STATUS_SYSEX  = 8'hF0;
    localparam logic [7:0] STATUS_ESCAPE = 8'hF7;
    localparam logic [7:0] STATUS_META   = 8'hFF;
    localparam logic [7:0] STATUS_QFRAME = 8'hF1;
    localparam logic [7:0] STATUS_SPP    = 8'hF2;
    localparam logic [7:0] STATUS_SONG   = 8'hF3;

    // One event result as it leaves the block.
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] abs_time;
        logic [15:0] event_status;
        logic [7:0]  data_length;
        logic [7:0]  inline_first;
        logic [7:0]  inline_second;
        logic [7:0]  payload_value;
        logic        last_of_event;
        logic        truncated;
    } result_t;

    // One queue entry: what a single input byte produced. It holds an event
    // result, a track end marker, or both; both share the same time.
    typedef struct packed {
        logic        has_event;
        logic        has_marker;
        logic        marker_truncated;
        logic [1:0]  kind;
        logic [31:0] abs_time;
        logic [15:0] event_status;
        logic [7:0]  data_length;
        logic [7:0]  inline_first;
        logic [7:0]  inline_second;
        logic [7:0]  payload_value;
        logic        last_of_event;
    } entry_t;

    // Number of inline data bytes that follow a channel or short system status.
    function automatic logic [7:0] inline_count(input logic [15:0] st);
        logic [7:0] cnt;
        cnt = 8'd0;
        unique case (st[7:4])
            4'h8, 4'h9, 4'hA, 4'hB, 4'hE: cnt = 8'd2;
            4'hC, 4'hD:                   cnt = 8'd1;
            default:                      cnt = 8'd0;
        endcase
        priority if (st == {8'h00, STATUS_SPP}) begin
            cnt = 8'd2;
        end else if (st == {8'h00, STATUS_QFRAME} || st == {8'h00, STATUS_SONG}) begin
            cnt = 8'd1;
        end else begin
            cnt = cnt;
        end
        return cnt;
    endfunction

endpackage

// ===== src/mtep_parse.sv =====
// Byte-level parse state machine of the MIDI track event parser.
// Depends on mtep_pkg; produces at most one queue entry per accepted byte.

module mtep_parse
    import mtep_pkg::*;
#(
    parameter int TIME_WIDTH = DEFAULT_TIME_WIDTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       accept,
    input  logic [7:0] track_byte,
    input  logic       end_of_track,
    output logic       push,
    output entry_t     entry
);

    typedef enum logic [2:0] {
        PH_DELTA,
        PH_DELTA_CONT,
        PH_STATUS,
        PH_DATA1,
        PH_DATA2,
        PH_META_TYPE,
        PH_LENGTH,
        PH_PAYLOAD
    } phase_t;

    phase_t                  phase_reg, phase_next;
    logic [15:0]             status_reg, status_next;
    logic [TIME_WIDTH-1:0]   time_reg, time_next;
    logic [TIME_WIDTH-1:0]   delta_reg, delta_next;
    logic [7:0]              left_reg, left_next;
    logic [7:0]              held_reg, held_next;
    logic [7:0]              len_reg, len_next;

    logic [TIME_WIDTH-1:0]   delta_shift;
    logic [7:0]              first_len;
    logic [7:0]              left_dec;
    logic                    do_delta;
    logic                    do_first;
    logic                    do_end;
    logic                    ev_valid;
    logic [1:0]              ev_kind;
    logic [15:0]             ev_status;
    logic [7:0]              ev_len;
    logic [7:0]              ev_first;
    logic [7:0]              ev_second;
    logic [7:0]              ev_payload;
    logic                    ev_last;
    logic                    mark_trunc;

    assign delta_shift = {delta_reg[TIME_WIDTH-8:0], track_byte[6:0] & VLV_MASK[6:0]};
    assign left_dec    = left_reg - 8'd1;

    always_comb begin
        phase_next  = phase_reg;
        status_next = status_reg;
        time_next   = time_reg;
        delta_next  = delta_reg;
        left_next   = left_reg;
        held_next   = held_reg;
        len_next    = len_reg;
        do_delta    = 1'b0;
        do_first    = 1'b0;
        do_end      = 1'b0;
        first_len   = len_reg;
        ev_valid    = 1'b0;
        ev_kind     = KIND_HEADER;
        ev_status   = status_reg;
        ev_len      = len_reg;
        ev_first    = 8'd0;
        ev_second   = 8'd0;
        ev_payload  = 8'd0;
        ev_last     = 1'b0;
        mark_trunc  = 1'b0;

        unique case (phase_reg)
            PH_DELTA, PH_DELTA_CONT: begin
                do_delta = 1'b1;
            end
            PH_STATUS: begin
                if ((track_byte & STATUS_BIT) == 8'd0) begin
                    if (status_reg == 16'd0) begin
                        // No running status: the byte opens the next delta time.
                        do_delta = 1'b1;
                    end else begin
                        first_len = inline_count(status_reg);
                        len_next  = first_len;
                        do_first  = 1'b1;
                    end
                end else begin
                    status_next = {8'h00, track_byte};
                    priority if (track_byte == STATUS_META) begin
                        phase_next = PH_META_TYPE;
                    end else if (track_byte == STATUS_SYSEX || track_byte == STATUS_ESCAPE) begin
                        phase_next = PH_LENGTH;
                    end else begin
                        len_next = inline_count({8'h00, track_byte});
                        if (inline_count({8'h00, track_byte}) == 8'd0) begin
                            ev_valid  = 1'b1;
                            ev_status = {8'h00, track_byte};
                            ev_len    = 8'd0;
                            ev_last   = 1'b1;
                            do_end    = 1'b1;
                        end else begin
                            phase_next = PH_DATA1;
                        end
                    end
                end
            end
            PH_DATA1: begin
                do_first = 1'b1;
            end
            PH_DATA2: begin
                ev_valid  = 1'b1;
                ev_first  = held_reg;
                ev_second = track_byte;
                ev_last   = 1'b1;
                do_end    = 1'b1;
            end
            PH_META_TYPE: begin
                status_next = {STATUS_META, track_byte};
                phase_next  = PH_LENGTH;
            end
            PH_LENGTH: begin
                len_next  = track_byte;
                left_next = track_byte;
                ev_valid  = 1'b1;
                ev_len    = track_byte;
                ev_last   = (track_byte == 8'd0);
                if (track_byte == 8'd0) begin
                    do_end = 1'b1;
                end else begin
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                left_next  = left_dec;
                ev_valid   = 1'b1;
                ev_kind    = KIND_PAYLOAD;
                ev_payload = track_byte;
                ev_last    = (left_dec == 8'd0);
                do_end     = (left_dec == 8'd0);
            end
            default: begin
                phase_next = PH_DELTA;
            end
        endcase

        if (do_first) begin
            held_next = track_byte;
            if (first_len >= 8'd2) begin
                phase_next = PH_DATA2;
            end else begin
                ev_valid = 1'b1;
                ev_len   = first_len;
                ev_first = track_byte;
                ev_last  = 1'b1;
                do_end   = 1'b1;
            end
        end

        if (do_delta) begin
            if ((track_byte & STATUS_BIT) != 8'd0) begin
                delta_next = delta_shift;
                phase_next = PH_DELTA_CONT;
            end else begin
                time_next  = time_reg + delta_shift;
                delta_next = '0;
                phase_next = PH_STATUS;
            end
        end

        // System and meta messages do not leave a running status behind.
        if (do_end) begin
            if (status_next >= {8'h00, SYSTEM_BASE}) begin
                status_next = 16'd0;
            end
            phase_next = PH_DELTA;
        end

        mark_trunc = (phase_next != PH_DELTA);

        entry.has_event        = ev_valid;
        entry.has_marker       = end_of_track;
        entry.marker_truncated = mark_trunc;
        entry.kind             = ev_kind;
        entry.abs_time         = 32'(time_next);
        entry.event_status     = ev_status;
        entry.data_length      = ev_len;
        entry.inline_first     = ev_first;
        entry.inline_second    = ev_second;
        entry.payload_value    = ev_payload;
        entry.last_of_event    = ev_last;

        push = accept && (ev_valid || end_of_track);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_DELTA;
            status_reg <= 16'd0;
            time_reg   <= '0;
            delta_reg  <= '0;
            left_reg   <= 8'd0;
            held_reg   <= 8'd0;
            len_reg    <= 8'd0;
        end else if (accept) begin
            if (end_of_track) begin
                phase_reg  <= PH_DELTA;
                status_reg <= 16'd0;
                time_reg   <= '0;
                delta_reg  <= '0;
                left_reg   <= 8'd0;
                held_reg   <= 8'd0;
                len_reg    <= 8'd0;
            end else begin
                phase_reg  <= phase_next;
                status_reg <= status_next;
                time_reg   <= time_next;
                delta_reg  <= delta_next;
                left_reg   <= left_next;
                held_reg   <= held_next;
                len_reg    <= len_next;
            end
        end
    end

endmodule

// ===== src/mtep_outq.sv =====
// Two-entry result queue of the MIDI track event parser.
// Depends on mtep_pkg; expands an entry into an event result and an end marker.

module mtep_outq
    import mtep_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  entry_t  entry,
    output logic    full,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    entry_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;
    logic               ev_done_reg;

    entry_t             head;
    logic               show_event;
    logic               xfer;
    logic               pop;

    assign head       = slot_reg[rd_ptr_reg];
    assign full       = (count_reg == (PTR_W+1)'(DEPTH));
    assign out_valid  = (count_reg != '0);
    assign show_event = head.has_event && !ev_done_reg;
    assign xfer       = out_valid && out_ready;
    // An entry with both parts stays until its marker has gone out too.
    assign pop        = xfer && !(show_event && head.has_marker);

    always_comb begin
        if (show_event) begin
            out_result.kind          = head.kind;
            out_result.event_status  = head.event_status;
            out_result.data_length   = head.data_length;
            out_result.inline_first  = head.inline_first;
            out_result.inline_second = head.inline_second;
            out_result.payload_value = head.payload_value;
            out_result.last_of_event = head.last_of_event;
            out_result.truncated     = 1'b0;
        end else begin
            out_result.kind          = KIND_END;
            out_result.event_status  = 16'd0;
            out_result.data_length   = 8'd0;
            out_result.inline_first  = 8'd0;
            out_result.inline_second = 8'd0;
            out_result.payload_value = 8'd0;
            out_result.last_of_event = 1'b0;
            out_result.truncated     = head.marker_truncated;
        end
        out_result.abs_time = head.abs_time;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
            ev_done_reg <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg  <= rd_ptr_reg + 1'b1;
                ev_done_reg <= 1'b0;
            end else if (xfer) begin
                ev_done_reg <= 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== src/midi_track_event_parser_unit.sv =====
// Top level of the MIDI track event parser.
// Depends on mtep_pkg, mtep_parse and mtep_outq.

// This unit takes the raw bytes of one MIDI file track chunk, one byte per
// transfer on the s_ channel, and returns the track's events on the m_
// channel. Each delta time is a variable-length value that is added to a
// running absolute time, which wraps at TIME_WIDTH bits; m_abs_time shows its
// low 32 bits. Channel and short system messages come out as one header
// result with their inline data bytes, and SysEx and meta messages as one
// header followed by one result for each payload byte. A byte marked with
// s_end_of_track ends the track: after any result of that byte a track end
// marker follows, with m_truncated set when an event was left incomplete,
// and the parser is back in its reset state for the next track. The unit
// takes one byte in every clock cycle while s_ready is high. Each byte is
// parsed in the cycle of its transfer, and its result is held in a
// two-entry result queue and offered on the m_ side once it reaches the
// head. A byte that yields an event result and the end marker goes out
// as two results, so s_ready drops only when the queue is full because
// the consumer stalls or a track end doubles the output.

module midi_track_event_parser_unit
    import mtep_pkg::*;
#(
    parameter int TIME_WIDTH = DEFAULT_TIME_WIDTH
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_track_byte,
    input  logic        s_end_of_track,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [31:0] m_abs_time,
    output logic [15:0] m_event_status,
    output logic [7:0]  m_data_length,
    output logic [7:0]  m_inline_first,
    output logic [7:0]  m_inline_second,
    output logic [7:0]  m_payload_value,
    output logic        m_last_of_event,
    output logic        m_truncated
);

    logic    accept;
    logic    push;
    logic    queue_full;
    entry_t  entry;
    result_t result;

    // A byte is taken whenever the queue has room for what it may produce.
    assign s_ready = !queue_full;
    assign accept  = s_valid && s_ready;

    mtep_parse #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_parse (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .track_byte   (s_track_byte),
        .end_of_track (s_end_of_track),
        .push         (push),
        .entry        (entry)
    );

    mtep_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .entry      (entry),
        .full       (queue_full),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_result (result)
    );

    assign m_kind          = result.kind;
    assign m_abs_time      = result.abs_time;
    assign m_event_status  = result.event_status;
    assign m_data_length   = result.data_length;
    assign m_inline_first  = result.inline_first;
    assign m_inline_second = result.inline_second;
    assign m_payload_value = result.payload_value;
    assign m_last_of_event = result.last_of_event;
    assign m_truncated     = result.truncated;

endmodule
